// ----- rtl/double_bank_tdm_calendar_top_defines.svh -----
// ----------------------------------------------------------------------------
// double_bank_tdm_calendar_top_defines
// Assertion macros used by the calendar top.
// ----------------------------------------------------------------------------
`ifndef DOUBLE_BANK_TDM_CALENDAR_TOP_DEFINES_SVH
`define DOUBLE_BANK_TDM_CALENDAR_TOP_DEFINES_SVH

// same-cycle implication, sampled on clk, off while in reset
`define DBTC_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off while in reset
`define DBTC_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/dbtc_pkg.sv -----
// ----------------------------------------------------------------------------
// dbtc_pkg
// Entry layout, item kinds and memory control shared by the calendar RTL.
// ----------------------------------------------------------------------------
`default_nettype none

package dbtc_pkg;

	typedef enum logic [1:0] {
		KIND_LOAD   = 2'd0,
		KIND_REPLAY = 2'd1,
		KIND_SELECT = 2'd2,
		KIND_UNUSED = 2'd3
	} kind_t;

	// bit 12 valid, 11..9 input port, 8..4 output mask, 3..0 opcode
	typedef struct packed {
		logic       valid;
		logic [2:0] in_port;
		logic [4:0] out_mask;
		logic [3:0] opcode;
	} entry_t;

	typedef struct packed {
		logic wr;
		logic rd;
	} mem_ctl_t;

	localparam logic STATUS_OK     = 1'b0;
	localparam logic STATUS_REJECT = 1'b1;

endpackage

`default_nettype wire

// ----- rtl/dbtc_cal_mem.sv -----
// ----------------------------------------------------------------------------
// dbtc_cal_mem
// Calendar entry store: one write port, one registered read port, and a
// clearing sweep over every entry after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module dbtc_cal_mem #(
	parameter int DEPTH = 128
) (
	input  wire                         clk,
	input  wire                         arst_n,
	input  dbtc_pkg::mem_ctl_t          ctl,
	input  wire  [$clog2(DEPTH)-1:0]    wr_addr,
	input  dbtc_pkg::entry_t            wr_data,
	input  wire  [$clog2(DEPTH)-1:0]    rd_addr,
	output dbtc_pkg::entry_t            rd_data,
	output logic                        busy
);

	localparam int AW = $clog2(DEPTH);

	dbtc_pkg::entry_t mem [DEPTH];
	dbtc_pkg::entry_t rd_q;
	logic             clr_q;
	logic [AW-1:0]    clr_idx_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q     <= 1'b1;
			clr_idx_q <= '0;
		end else if (clr_q) begin
			if (clr_idx_q == AW'(DEPTH - 1)) begin
				clr_q <= 1'b0;
			end
			clr_idx_q <= clr_idx_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (clr_q) begin
			mem[clr_idx_q] <= '0;
		end else if (ctl.wr) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// hold read data unless a new read is issued
	always_ff @(posedge clk) begin
		if (ctl.rd) begin
			rd_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_q;
	assign busy    = clr_q;

endmodule

`default_nettype wire

// ----- rtl/double_bank_tdm_calendar_top.sv -----
// ----------------------------------------------------------------------------
// double_bank_tdm_calendar_top
// Two-bank time-division calendar: loads entries, replays the entry for a
// cycle from the active bank, and switches the active bank.
// ----------------------------------------------------------------------------
//
//  channel | handshake              | payload
//  --------+------------------------+-------------------------------------------
//  input   | in_valid / in_stall    | kind bank slot cycle entry_valid
//          |                        | entry_in_port entry_out_mask entry_opcode
//  output  | out_valid / out_stall  | status hit out_in_port out_mask
//          |                        | out_opcode
//
// One word in and one word out per cycle while in_stall and out_stall are low:
// two stages reduce the cycle modulo SLOTS by a reciprocal multiply, the third
// is the memory access (write for a load, registered read for a replay).
// After reset the store clears all 2*SLOTS entries with in_stall high.
// out_stall holds the output word; stages behind it keep filling bubbles.
// ----------------------------------------------------------------------------
`default_nettype none

module double_bank_tdm_calendar_top #(
	parameter int SLOTS = 64,
	parameter int PORTS = 5
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         in_valid,
	output logic        in_stall,
	input  wire  [1:0]  kind,
	input  wire         bank,
	input  wire  [9:0]  slot,
	input  wire  [31:0] cycle,
	input  wire         entry_valid,
	input  wire  [2:0]  entry_in_port,
	input  wire  [4:0]  entry_out_mask,
	input  wire  [3:0]  entry_opcode,
	output logic        out_valid,
	input  wire         out_stall,
	output logic        status,
	output logic        hit,
	output logic [2:0]  out_in_port,
	output logic [4:0]  out_mask,
	output logic [3:0]  out_opcode
);

	localparam int          DEPTH = 2 * SLOTS;
	localparam int          AW    = $clog2(DEPTH);
	localparam int          RW    = $clog2(DEPTH) + 1;
	localparam logic [31:0] RECIP = 32'(64'h0000_0000_FFFF_FFFF / SLOTS);

	// stage valids and advance enables
	logic v1_q, v2_q, v3_q;
	logic en1, en2, en3;
	logic mem_busy;

	// input decode
	dbtc_pkg::kind_t  kind_in;
	logic             slot_ok, port_ok, reject_in;
	dbtc_pkg::entry_t word_in;
	logic [AW-1:0]    waddr_in;

	// stage payloads
	dbtc_pkg::kind_t  kind_s1, kind_s2, kind_s3;
	logic             bank_s1, bank_s2;
	logic             reject_s1, reject_s2, status_s3;
	dbtc_pkg::entry_t word_s1, word_s2;
	logic [AW-1:0]    waddr_s1, waddr_s2;
	logic [31:0]      cycle_s1;
	logic [63:0]      prod_s1;
	logic [RW-1:0]    rem_s2;

	// memory stage
	logic [RW-1:0]      idx;
	logic [AW-1:0]      raddr;
	dbtc_pkg::mem_ctl_t mem_ctl;
	dbtc_pkg::entry_t   rd_word;
	logic               sel_bank_q;
	logic               replay_s3;
	logic               ok_s3, load_s3;

	assign en3      = !v3_q || !out_stall;
	assign en2      = !v2_q || en3;
	assign en1      = !v1_q || en2;
	assign in_stall = !en1 || mem_busy;

	assign kind_in   = dbtc_pkg::kind_t'(kind);
	assign slot_ok   = {1'b0, slot} < 11'(SLOTS);
	assign port_ok   = {1'b0, entry_in_port} < 4'(PORTS);
	assign reject_in = (kind_in == dbtc_pkg::KIND_LOAD) && (!slot_ok || (entry_valid && !port_ok));
	assign waddr_in  = bank ? AW'(slot) + AW'(SLOTS) : AW'(slot);

	// a bad port packs as all zeros
	always_comb begin
		word_in = '0;
		if (port_ok) begin
			word_in.valid    = entry_valid;
			word_in.in_port  = entry_in_port;
			word_in.out_mask = entry_out_mask;
			word_in.opcode   = entry_opcode;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q       <= 1'b0;
			v2_q       <= 1'b0;
			v3_q       <= 1'b0;
			sel_bank_q <= 1'b0;
		end else begin
			if (en1) begin
				v1_q <= in_valid && !mem_busy;
			end
			if (en2) begin
				v2_q <= v1_q;
			end
			if (en3) begin
				v3_q <= v2_q;
				if (v2_q && kind_s2 == dbtc_pkg::KIND_SELECT) begin
					sel_bank_q <= bank_s2;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			kind_s1   <= kind_in;
			bank_s1   <= bank;
			reject_s1 <= reject_in;
			word_s1   <= word_in;
			waddr_s1  <= waddr_in;
			cycle_s1  <= cycle;
			prod_s1   <= 64'(cycle) * 64'(RECIP);
		end
		if (en2) begin
			kind_s2   <= kind_s1;
			bank_s2   <= bank_s1;
			reject_s2 <= reject_s1;
			word_s2   <= word_s1;
			waddr_s2  <= waddr_s1;
			// quotient estimate is low by at most one, so this is below 2*SLOTS
			rem_s2    <= RW'(cycle_s1 - prod_s1[63:32] * 32'(SLOTS));
		end
		if (en3) begin
			kind_s3   <= kind_s2;
			status_s3 <= reject_s2 ? dbtc_pkg::STATUS_REJECT : dbtc_pkg::STATUS_OK;
		end
	end

	assign idx   = (rem_s2 >= RW'(SLOTS)) ? rem_s2 - RW'(SLOTS) : rem_s2;
	assign raddr = sel_bank_q ? AW'(idx) + AW'(SLOTS) : AW'(idx);

	assign mem_ctl.wr = en3 && v2_q && (kind_s2 == dbtc_pkg::KIND_LOAD) && !reject_s2;
	assign mem_ctl.rd = en3 && v2_q && (kind_s2 == dbtc_pkg::KIND_REPLAY);

	dbtc_cal_mem #(
		.DEPTH (DEPTH)
	) u_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (mem_ctl),
		.wr_addr (waddr_s2),
		.wr_data (word_s2),
		.rd_addr (raddr),
		.rd_data (rd_word),
		.busy    (mem_busy)
	);

	assign replay_s3   = kind_s3 == dbtc_pkg::KIND_REPLAY;
	assign load_s3     = kind_s3 == dbtc_pkg::KIND_LOAD;
	assign ok_s3       = status_s3 == dbtc_pkg::STATUS_OK;
	assign out_valid   = v3_q;
	assign status      = status_s3;
	assign hit         = replay_s3 && rd_word.valid && ({1'b0, rd_word.in_port} < 4'(PORTS));
	assign out_in_port = replay_s3 ? rd_word.in_port : '0;
	assign out_mask    = replay_s3 ? rd_word.out_mask : '0;
	assign out_opcode  = replay_s3 ? rd_word.opcode : '0;

`include "double_bank_tdm_calendar_top_defines.svh"

	`DBTC_ASSERT_IMP(a_clear_blocks_input, mem_busy, in_stall && !v1_q && !v2_q, "busy leak")
	`DBTC_ASSERT_IMP(a_hit_only_on_replay, out_valid && hit, replay_s3 && ok_s3, "stray hit")
	`DBTC_ASSERT_IMP(a_reject_only_on_load, out_valid && !ok_s3, load_s3 && !hit, "stray reject")
	`DBTC_ASSERT_NXT(a_s2_holds, v2_q && !en3, v2_q && $stable(rem_s2), "stage two lost")

endmodule

`default_nettype wire

// ----- test/double_bank_tdm_calendar_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// double_bank_tdm_calendar_checker
// Watches both channels of the calendar and keeps its own copy of the two
// banks and the active bank. It predicts the result word for every accepted
// input word and compares each accepted output word, field by field, with the
// oldest prediction.
// ----------------------------------------------------------------------------

module double_bank_tdm_calendar_checker #(
	parameter int SLOTS = 64,
	parameter int PORTS = 5
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         in_valid,
	input  wire         in_stall,
	input  wire  [1:0]  kind,
	input  wire         bank,
	input  wire  [9:0]  slot,
	input  wire  [31:0] cycle,
	input  wire         entry_valid,
	input  wire  [2:0]  entry_in_port,
	input  wire  [4:0]  entry_out_mask,
	input  wire  [3:0]  entry_opcode,
	input  wire         out_valid,
	input  wire         out_stall,
	input  wire         status,
	input  wire         hit,
	input  wire  [2:0]  out_in_port,
	input  wire  [4:0]  out_mask,
	input  wire  [3:0]  out_opcode,
	output int          fail_count,
	output int          pending
);

	typedef struct packed {
		logic       status;
		logic       hit;
		logic [2:0] in_port;
		logic [4:0] port_mask;
		logic [3:0] opcode;
	} calendar_result_t;

	dbtc_pkg::entry_t calendar [2*SLOTS];
	logic             sel_bank;
	calendar_result_t expected_words [$];

	function automatic calendar_result_t apply_word(input logic [1:0] k, input logic b,
			input logic [9:0] s, input logic [31:0] cyc, input logic v,
			input logic [2:0] p, input logic [4:0] m, input logic [3:0] op);
		calendar_result_t res;
		dbtc_pkg::entry_t e;
		int unsigned      idx;
		res = '0;
		res.status = dbtc_pkg::STATUS_OK;
		case (dbtc_pkg::kind_t'(k))
			dbtc_pkg::KIND_LOAD: begin
				if (s >= SLOTS || (v && p >= PORTS)) begin
					res.status = dbtc_pkg::STATUS_REJECT;
				end else begin
					// an invalid entry with a bad port lands as all zeros
					e = '0;
					if (p < PORTS) begin
						e.valid    = v;
						e.in_port  = p;
						e.out_mask = m;
						e.opcode   = op;
					end
					calendar[int'(b) * SLOTS + int'(s)] = e;
				end
			end
			dbtc_pkg::KIND_REPLAY: begin
				idx = cyc % SLOTS;
				e = calendar[int'(sel_bank) * SLOTS + idx];
				res.hit       = e.valid && (e.in_port < PORTS);
				res.in_port   = e.in_port;
				res.port_mask = e.out_mask;
				res.opcode    = e.opcode;
			end
			dbtc_pkg::KIND_SELECT: begin
				sel_bank = b;
			end
			default: begin
			end
		endcase
		return res;
	endfunction

	task automatic check_field(input string name, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		calendar_result_t want;
		if (!arst_n) begin
			for (int i = 0; i < 2*SLOTS; i++)
				calendar[i] = '0;
			sel_bank = 1'b0;
			expected_words.delete();
			pending = 0;
		end else begin
			// retire the output word before taking the new input word
			if (out_valid && !out_stall) begin
				if (expected_words.size() == 0) begin
					$error("result word arrived with none expected");
					fail_count++;
				end else begin
					want = expected_words.pop_front();
					check_field("status", 32'(want.status), 32'(status));
					check_field("hit", 32'(want.hit), 32'(hit));
					check_field("out_in_port", 32'(want.in_port), 32'(out_in_port));
					check_field("out_mask", 32'(want.port_mask), 32'(out_mask));
					check_field("out_opcode", 32'(want.opcode), 32'(out_opcode));
				end
			end
			if (in_valid && !in_stall)
				expected_words.push_back(apply_word(kind, bank, slot, cycle, entry_valid,
					entry_in_port, entry_out_mask, entry_opcode));
			pending = expected_words.size();
		end
	end

endmodule

// ----- test/double_bank_tdm_calendar_top_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// double_bank_tdm_calendar_top_tb
// Drives load, replay, select and unused words into the calendar: a directed opening
// over the slot and port limits, then random traffic under changing idle
// rates on both sides and one long output hold-off. The checker beside the
// block predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------

module double_bank_tdm_calendar_top_tb;

	localparam int SLOTS       = 64;
	localparam int PORTS       = 5;
	localparam int ITEMS       = 1000;
	localparam int LIMIT       = 200000;
	localparam int HOLD_CYCLES = 300;

	logic        clk            = 1'b0;
	logic        arst_n         = 1'b0;
	logic        in_valid       = 1'b0;
	logic [1:0]  kind           = '0;
	logic        bank           = 1'b0;
	logic [9:0]  slot           = '0;
	logic [31:0] cycle          = '0;
	logic        entry_valid    = 1'b0;
	logic [2:0]  entry_in_port  = '0;
	logic [4:0]  entry_out_mask = '0;
	logic [3:0]  entry_opcode   = '0;
	logic        out_stall      = 1'b0;

	logic        in_stall;
	logic        out_valid;
	logic        status;
	logic        hit;
	logic [2:0]  out_in_port;
	logic [4:0]  out_mask;
	logic [3:0]  out_opcode;

	int fail_count;
	int pending;
	int cycle_count = 0;
	int phase       = 0;
	int tx_idle_pct = 19;
	int rx_idle_pct = 52;

	double_bank_tdm_calendar_top #(
		.SLOTS(SLOTS),
		.PORTS(PORTS)
	) u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.kind(kind), .bank(bank), .slot(slot), .cycle(cycle),
		.entry_valid(entry_valid), .entry_in_port(entry_in_port),
		.entry_out_mask(entry_out_mask), .entry_opcode(entry_opcode),
		.out_valid(out_valid), .out_stall(out_stall),
		.status(status), .hit(hit), .out_in_port(out_in_port),
		.out_mask(out_mask), .out_opcode(out_opcode)
	);

	double_bank_tdm_calendar_checker #(
		.SLOTS(SLOTS),
		.PORTS(PORTS)
	) u_checker (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.kind(kind), .bank(bank), .slot(slot), .cycle(cycle),
		.entry_valid(entry_valid), .entry_in_port(entry_in_port),
		.entry_out_mask(entry_out_mask), .entry_opcode(entry_opcode),
		.out_valid(out_valid), .out_stall(out_stall),
		.status(status), .hit(hit), .out_in_port(out_in_port),
		.out_mask(out_mask), .out_opcode(out_opcode),
		.fail_count(fail_count), .pending(pending)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// output side: random stall, plus one long hold-off at the start of the last phase
	initial begin
		int  hold_left;
		bit  hold_done;
		hold_left = 0;
		hold_done = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else if (phase == 2 && !hold_done) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES - 1;
				out_stall <= 1'b1;
			end else begin
				out_stall <= ($urandom_range(99) < rx_idle_pct);
			end
		end
	end

	task automatic send_word(input dbtc_pkg::kind_t k, input logic b, input logic [9:0] s,
			input logic [31:0] cyc, input logic v, input logic [2:0] p,
			input logic [4:0] m, input logic [3:0] op);
		while ($urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid       <= 1'b1;
		kind           <= k;
		bank           <= b;
		slot           <= s;
		cycle          <= cyc;
		entry_valid    <= v;
		entry_in_port  <= p;
		entry_out_mask <= m;
		entry_opcode   <= op;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	// replay, select or unused word with random entry fields
	task automatic send_misc(input dbtc_pkg::kind_t k, input logic b, input logic [31:0] cyc);
		send_word(k, b, 10'($urandom), cyc, 1'($urandom), 3'($urandom), 5'($urandom),
			4'($urandom));
	endtask

	initial begin
		int          pick;
		logic [9:0]  s;
		logic        v;
		logic [2:0]  p;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// empty store, then the slot and port limits on both banks
		send_misc(dbtc_pkg::KIND_REPLAY, 1'($urandom), 32'd0);
		send_word(dbtc_pkg::KIND_LOAD, 1'b0, 10'd0, $urandom, 1'b1, 3'd0, 5'h1F, 4'hF);
		send_word(dbtc_pkg::KIND_LOAD, 1'b0, 10'd63, $urandom, 1'b1, 3'd4, 5'h00, 4'h0);
		send_word(dbtc_pkg::KIND_LOAD, 1'b1, 10'd0, $urandom, 1'b1, 3'd3, 5'h15, 4'hA);
		send_word(dbtc_pkg::KIND_LOAD, 1'b0, 10'd64, $urandom, 1'b1, 3'd1, 5'h0F, 4'h3);
		send_word(dbtc_pkg::KIND_LOAD, 1'b1, 10'd1023, $urandom, 1'b0, 3'd2, 5'h1F, 4'hF);
		send_word(dbtc_pkg::KIND_LOAD, 1'b0, 10'd5, $urandom, 1'b1, 3'd5, 5'h1F, 4'hF);
		send_word(dbtc_pkg::KIND_LOAD, 1'b0, 10'd6, $urandom, 1'b1, 3'd7, 5'h0A, 4'h5);
		send_word(dbtc_pkg::KIND_LOAD, 1'b0, 10'd7, $urandom, 1'b0, 3'd2, 5'h1F, 4'h9);
		send_misc(dbtc_pkg::KIND_REPLAY, 1'($urandom), 32'd7);
		send_misc(dbtc_pkg::KIND_REPLAY, 1'($urandom), 32'd0);
		send_misc(dbtc_pkg::KIND_REPLAY, 1'($urandom), 32'hFFFF_FFFF);
		send_misc(dbtc_pkg::KIND_REPLAY, 1'($urandom), 32'd64);
		// invalid entry with a bad port wipes slot 0
		send_word(dbtc_pkg::KIND_LOAD, 1'b0, 10'd0, $urandom, 1'b0, 3'd7, 5'h1F, 4'hF);
		send_misc(dbtc_pkg::KIND_REPLAY, 1'($urandom), 32'd0);
		send_misc(dbtc_pkg::KIND_SELECT, 1'b1, $urandom);
		send_misc(dbtc_pkg::KIND_REPLAY, 1'($urandom), 32'h8000_0000);
		send_misc(dbtc_pkg::KIND_UNUSED, 1'($urandom), $urandom);
		send_misc(dbtc_pkg::KIND_REPLAY, 1'($urandom), 32'd5);
		send_misc(dbtc_pkg::KIND_SELECT, 1'b0, $urandom);
		send_misc(dbtc_pkg::KIND_REPLAY, 1'($urandom), 32'd63);
		send_misc(dbtc_pkg::KIND_REPLAY, 1'($urandom), 32'd5);
		send_misc(dbtc_pkg::KIND_REPLAY, 1'($urandom), 32'd6);

		for (int i = 0; i < ITEMS; i++) begin
			phase = i * 3 / ITEMS;
			tx_idle_pct = (phase == 0) ? 19 : (phase == 1) ? 52 : 0;
			rx_idle_pct = (phase == 0) ? 52 : (phase == 1) ? 19 : 0;
			pick = $urandom_range(99);
			if (pick < 40) begin
				// mostly legal loads so replays find live entries
				s = ($urandom_range(9) == 0) ? 10'($urandom_range(1023)) :
					10'($urandom_range(SLOTS - 1));
				v = ($urandom_range(9) != 0);
				p = ($urandom_range(7) == 0) ? 3'($urandom_range(7)) :
					3'($urandom_range(PORTS - 1));
				send_word(dbtc_pkg::KIND_LOAD, 1'($urandom), s, $urandom, v, p,
					5'($urandom), 4'($urandom));
			end else if (pick < 80) begin
				send_misc(dbtc_pkg::KIND_REPLAY, 1'($urandom), $urandom);
			end else if (pick < 95) begin
				send_misc(dbtc_pkg::KIND_SELECT, 1'($urandom), $urandom);
			end else begin
				send_misc(dbtc_pkg::KIND_UNUSED, 1'($urandom), $urandom);
			end
		end

		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
